### design/stm_pkg.sv
// ----------------------------------------------------------------------------
// Trimmed-mean filter package
// Widths and constants shared by the trimmed-mean weight filter modules.
// ----------------------------------------------------------------------------
package stm_pkg;

    // Weight samples and results: signed, units of 1/16 gram.
    localparam int WEIGHT_W = 24;

    // Default number of samples in the sliding window.
    localparam int DEFAULT_WINDOW_LENGTH = 5;

    // Samples below -900 g (-14400 sixteenths) are read-error marks.
    localparam logic signed [WEIGHT_W-1:0] ERROR_LIMIT = -24'sd14400;

endpackage

### design/stm_recip_div.sv
// ----------------------------------------------------------------------------
// Trimmed sum divider
// Removes the minimum and maximum from the window sum and divides the result
// by a constant, rounding toward zero, in two pipeline stages.
// ----------------------------------------------------------------------------
module stm_recip_div
    import stm_pkg::*;
#(
    parameter int SUM_W   = WEIGHT_W + 3,
    parameter int DIVISOR = DEFAULT_WINDOW_LENGTH - 2
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       in_held,
    input  logic signed [SUM_W-1:0]    in_sum,
    input  logic signed [WEIGHT_W-1:0] in_lo,
    input  logic signed [WEIGHT_W-1:0] in_hi,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       out_held,
    output logic [WEIGHT_W-1:0]        out_quot
);

    // The trimmed sum magnitude stays below 2**MAG_W, which makes the
    // rounded-up reciprocal exact for every reachable value.
    localparam int MAG_W   = SUM_W - 1;
    localparam int SHIFT_L = $clog2(DIVISOR);
    localparam int SHIFT   = MAG_W + SHIFT_L;
    localparam int RECIP_W = MAG_W + 2;
    localparam int PROD_W  = MAG_W + RECIP_W;
    localparam int QUO_W   = PROD_W - SHIFT;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

    logic                    a_valid_reg;
    logic                    a_held_reg;
    logic                    a_neg_reg;
    logic [MAG_W-1:0]        a_mag_reg;
    logic                    b_valid_reg;
    logic                    b_held_reg;
    logic                    b_neg_reg;
    logic [PROD_W-1:0]       b_prod_reg;

    logic                    a_ready;
    logic                    b_ready;
    logic signed [SUM_W-1:0] trim;
    logic signed [SUM_W-1:0] trim_abs;
    logic [MAG_W-1:0]        mag_next;
    logic [PROD_W-1:0]       prod_next;
    logic [QUO_W-1:0]        quot;
    logic signed [QUO_W:0]   quot_signed;

    assign b_ready  = !b_valid_reg || out_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    always_comb begin
        trim      = in_sum - SUM_W'(in_lo) - SUM_W'(in_hi);
        trim_abs  = trim[SUM_W-1] ? -trim : trim;
        mag_next  = trim_abs[MAG_W-1:0];
        prod_next = PROD_W'(a_mag_reg) * PROD_W'(RECIP);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            if (a_ready) begin
                a_valid_reg <= in_valid;
            end
            if (b_ready) begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (a_ready) begin
            a_held_reg <= in_held;
            a_neg_reg  <= trim[SUM_W-1];
            a_mag_reg  <= mag_next;
        end
        if (b_ready) begin
            b_held_reg <= a_held_reg;
            b_neg_reg  <= a_neg_reg;
            b_prod_reg <= prod_next;
        end
    end

    always_comb begin
        quot        = b_prod_reg[PROD_W-1:SHIFT];
        quot_signed = b_neg_reg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
    end

    assign out_valid = b_valid_reg;
    assign out_held  = b_held_reg;
    assign out_quot  = quot_signed[WEIGHT_W-1:0];

endmodule

### design/sliding_trimmed_mean_filter.sv
// ----------------------------------------------------------------------------
// Sliding trimmed-mean weight filter
// Smooths a load-cell sample stream with a mean that drops the window's
// smallest and largest samples.
// ----------------------------------------------------------------------------
// Usage
// The slave channel (s_*) takes one weight sample per item in s_tdata, signed
// in units of 1/16 gram. The master channel (m_*) returns exactly one result
// item for every sample: the trimmed mean in m_tdata and, in m_tuser, a flag
// that is set when the sample was a read error and the last result is repeated.
// A new item can be accepted in every clock cycle while the output is not
// stalled; the result of an item appears on m_tvalid once it has passed the
// pipeline registers in turn: window write, sum and extremes, trimmed
// magnitude, reciprocal multiply, output register.
// When the receiver holds m_tready low the pipeline fills its empty stages and
// then stalls; s_tready falls only once no stage can move. No item is lost.
// A synchronous low level on aresetn clears the window to zero samples, the
// write slot and the held result to zero, and empties the pipeline.
// ----------------------------------------------------------------------------
module sliding_trimmed_mean_filter
    import stm_pkg::*;
#(
    parameter int WINDOW_LENGTH = DEFAULT_WINDOW_LENGTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    // s_tdata[23:0]: weight sample
    input  logic [WEIGHT_W-1:0] s_tdata,
    input  logic                s_tvalid,
    output logic                s_tready,
    // m_tdata[23:0]: filtered_weight
    output logic [WEIGHT_W-1:0] m_tdata,
    // m_tuser[0]: held
    output logic                m_tuser,
    output logic                m_tvalid,
    input  logic                m_tready
);

    // Window bookkeeping and adder/compare tree sizes.
    localparam int SLOT_W = $clog2(WINDOW_LENGTH);
    localparam int LEVELS = $clog2(WINDOW_LENGTH);
    localparam int TREE_N = 1 << LEVELS;
    localparam int SUM_W  = WEIGHT_W + LEVELS;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_LENGTH - 1);

    // Window stage: the ring of samples and the slot of the oldest entry.
    logic signed [WEIGHT_W-1:0] window_reg [WINDOW_LENGTH];
    logic [SLOT_W-1:0]          slot_reg;
    logic [SLOT_W-1:0]          slot_next;
    logic                       w_valid_reg;
    logic                       w_held_reg;
    logic                       w_ready;
    logic                       accept;
    logic                       sample_error;

    // Reduction stage: window sum and its extremes.
    logic                       r_valid_reg;
    logic                       r_held_reg;
    logic signed [SUM_W-1:0]    r_sum_reg;
    logic signed [WEIGHT_W-1:0] r_lo_reg;
    logic signed [WEIGHT_W-1:0] r_hi_reg;
    logic                       r_ready;
    logic signed [SUM_W-1:0]    sum_next;
    logic signed [WEIGHT_W-1:0] lo_next;
    logic signed [WEIGHT_W-1:0] hi_next;
    logic signed [SUM_W-1:0]    sum_tree [TREE_N];
    logic signed [WEIGHT_W-1:0] lo_tree  [TREE_N];
    logic signed [WEIGHT_W-1:0] hi_tree  [TREE_N];

    // Divider and output register.
    logic                       div_in_ready;
    logic                       div_out_valid;
    logic                       div_out_held;
    logic [WEIGHT_W-1:0]        div_quot;
    logic                       out_ready;
    logic [WEIGHT_W-1:0]        last_result_reg;
    logic [WEIGHT_W-1:0]        out_data_reg;
    logic                       out_held_reg;
    logic                       out_valid_reg;

    // Each stage moves on when it is empty or the stage after it moves.
    assign out_ready = !out_valid_reg || m_tready;
    assign r_ready   = !r_valid_reg || div_in_ready;
    assign w_ready   = !w_valid_reg || r_ready;
    assign s_tready  = w_ready;
    assign accept    = s_tvalid && w_ready;

    // A read-error sample neither enters the window nor moves the slot.
    assign sample_error = $signed(s_tdata) < ERROR_LIMIT;
    assign slot_next    = (slot_reg == LAST_SLOT) ? '0 : slot_reg + 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < WINDOW_LENGTH; i++) begin
                window_reg[i] <= '0;
            end
            slot_reg    <= '0;
            w_valid_reg <= 1'b0;
            w_held_reg  <= 1'b0;
        end else begin
            if (w_ready) begin
                w_valid_reg <= s_tvalid;
                w_held_reg  <= sample_error;
            end
            if (accept && !sample_error) begin
                window_reg[slot_reg] <= $signed(s_tdata);
                slot_reg             <= slot_next;
            end
        end
    end

    // Sum, minimum and maximum of the window as balanced trees. The spare
    // leaves carry zero for the sum and the first entry for the extremes,
    // so they change neither.
    always_comb begin
        for (int i = 0; i < TREE_N; i++) begin
            if (i < WINDOW_LENGTH) begin
                sum_tree[i] = SUM_W'(window_reg[i]);
                lo_tree[i]  = window_reg[i];
                hi_tree[i]  = window_reg[i];
            end else begin
                sum_tree[i] = '0;
                lo_tree[i]  = window_reg[0];
                hi_tree[i]  = window_reg[0];
            end
        end
        for (int lvl = 0; lvl < LEVELS; lvl++) begin
            for (int i = 0; i < (TREE_N >> (lvl + 1)); i++) begin
                sum_tree[i] = sum_tree[2*i] + sum_tree[2*i+1];
                lo_tree[i]  = (lo_tree[2*i+1] < lo_tree[2*i]) ? lo_tree[2*i+1] : lo_tree[2*i];
                hi_tree[i]  = (hi_tree[2*i+1] > hi_tree[2*i]) ? hi_tree[2*i+1] : hi_tree[2*i];
            end
        end
        sum_next = sum_tree[0];
        lo_next  = lo_tree[0];
        hi_next  = hi_tree[0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r_valid_reg <= 1'b0;
        end else if (r_ready) begin
            r_valid_reg <= w_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (r_ready) begin
            r_held_reg <= w_held_reg;
            r_sum_reg  <= sum_next;
            r_lo_reg   <= lo_next;
            r_hi_reg   <= hi_next;
        end
    end

    stm_recip_div #(
        .SUM_W   (SUM_W),
        .DIVISOR (WINDOW_LENGTH - 2)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (r_valid_reg),
        .in_ready  (div_in_ready),
        .in_held   (r_held_reg),
        .in_sum    (r_sum_reg),
        .in_lo     (r_lo_reg),
        .in_hi     (r_hi_reg),
        .out_valid (div_out_valid),
        .out_ready (out_ready),
        .out_held  (div_out_held),
        .out_quot  (div_quot)
    );

    // Items leave the divider in order, so the held result is always that of
    // the newest good sample ahead of a read-error item.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg   <= 1'b0;
            last_result_reg <= '0;
        end else if (out_ready) begin
            out_valid_reg <= div_out_valid;
            if (div_out_valid && !div_out_held) begin
                last_result_reg <= div_quot;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready) begin
            out_data_reg <= div_out_held ? last_result_reg : div_quot;
            out_held_reg <= div_out_held;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_held_reg;

endmodule

### test/sliding_trimmed_mean_filter_tb.sv
// ----------------------------------------------------------------------------
// Sliding trimmed-mean filter testbench
// Drives weight samples into the filter and compares every result item with
// a local model of the window or a result written out by hand. The run
// starts with a short table of edge cases. Random load-cell traffic follows
// under three idling patterns, with one long hold-off of the receiver.
// ----------------------------------------------------------------------------
module sliding_trimmed_mean_filter_tb
    import stm_pkg::*;
();

    localparam int WIN          = DEFAULT_WINDOW_LENGTH;
    localparam int LATENCY      = 4;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int ITEMS_PER_PHASE = 200;
    localparam int LONG_HOLD    = 60;
    localparam int N_DIRECTED   = 23;

    // One result item as the filter reports it.
    typedef struct packed {
        logic signed [WEIGHT_W-1:0] weight;
        logic                       held;
    } reading_t;

    // One row of the directed table. Where typed is set, the result is
    // written out by hand; otherwise it comes from the window model.
    typedef struct {
        logic signed [WEIGHT_W-1:0] sample;
        bit                         typed;
        logic signed [WEIGHT_W-1:0] weight;
        bit                         held;
    } sample_row_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic [WEIGHT_W-1:0] s_tdata  = '0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [WEIGHT_W-1:0] m_tdata;
    logic                m_tuser;
    logic                m_tvalid;
    logic                m_tready = 1'b0;

    // Local copy of the filter state.
    logic signed [WEIGHT_W-1:0] window_samples [WIN];
    int unsigned                oldest_slot;
    logic signed [WEIGHT_W-1:0] held_weight;

    reading_t    pending_readings [$];
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;

    // Idling in percent of cycles, changed between phases.
    int unsigned send_idle = 0;
    int unsigned recv_idle = 0;
    bit          long_hold_armed = 1'b0;

    // Level around which the random load-cell samples wander.
    int load_level = 0;

    // The directed table: read errors straight after reset, both sides of the
    // error threshold, a window full of the largest and then of the smallest
    // storable sample, a repeated result after a settled window, ties of the
    // minimum and maximum, and a negative sum that must round toward zero.
    sample_row_t directed_rows [N_DIRECTED] = '{
        '{-24'sd8388608, 1'b1, 24'sd0, 1'b1},
        '{ 24'sd8388607, 1'b1, 24'sd0, 1'b0},
        '{   -24'sd14401, 1'b1, 24'sd0, 1'b1},
        '{   -24'sd14400, 1'b0, 24'sd0, 1'b0},
        '{ 24'sd8388607, 1'b0, 24'sd0, 1'b0},
        '{ 24'sd8388607, 1'b0, 24'sd0, 1'b0},
        '{ 24'sd8388607, 1'b0, 24'sd0, 1'b0},
        '{ 24'sd8388607, 1'b0, 24'sd0, 1'b0},
        '{ 24'sd8388607, 1'b0, 24'sd0, 1'b0},
        '{   -24'sd14400, 1'b0, 24'sd0, 1'b0},
        '{   -24'sd14400, 1'b0, 24'sd0, 1'b0},
        '{   -24'sd14400, 1'b0, 24'sd0, 1'b0},
        '{   -24'sd14400, 1'b0, 24'sd0, 1'b0},
        '{   -24'sd14400, 1'b0, 24'sd0, 1'b0},
        '{   -24'sd14401, 1'b0, 24'sd0, 1'b0},
        '{        24'sd1, 1'b0, 24'sd0, 1'b0},
        '{        24'sd2, 1'b0, 24'sd0, 1'b0},
        '{       -24'sd7, 1'b0, 24'sd0, 1'b0},
        '{       -24'sd5, 1'b0, 24'sd0, 1'b0},
        '{       -24'sd5, 1'b0, 24'sd0, 1'b0},
        '{-24'sd8388607, 1'b0, 24'sd0, 1'b0},
        '{        24'sd3, 1'b0, 24'sd0, 1'b0},
        '{        24'sd0, 1'b0, 24'sd0, 1'b0}
    };

    sliding_trimmed_mean_filter #(
        .WINDOW_LENGTH(WIN)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Advances the window model by one sample and returns the result item that
    // the filter should give for it. A read error leaves the window alone and
    // repeats the held result.
    function automatic reading_t trimmed_mean_step(logic signed [WEIGHT_W-1:0] sample);
        reading_t                   r;
        longint                     total;
        logic signed [WEIGHT_W-1:0] lowest;
        logic signed [WEIGHT_W-1:0] highest;
        if (sample < ERROR_LIMIT) begin
            r.held = 1'b1;
        end else begin
            window_samples[oldest_slot] = sample;
            oldest_slot = (oldest_slot + 1) % WIN;
            total   = 0;
            lowest  = window_samples[0];
            highest = window_samples[0];
            for (int i = 0; i < WIN; i++) begin
                total += longint'(window_samples[i]);
                if (window_samples[i] < lowest) lowest = window_samples[i];
                if (window_samples[i] > highest) highest = window_samples[i];
            end
            total -= longint'(lowest) + longint'(highest);
            // Signed division truncates toward zero, as the filter must.
            held_weight = WEIGHT_W'(total / longint'(WIN - 2));
            r.held = 1'b0;
        end
        r.weight = held_weight;
        return r;
    endfunction

    // Random sample: mostly a noisy load-cell level that jumps now and then,
    // with read errors, samples over the whole 24-bit range and the values
    // around the error threshold mixed in.
    function automatic logic signed [WEIGHT_W-1:0] random_sample();
        int unsigned pick;
        int          v;
        pick = $urandom_range(99);
        if (pick < 10) begin
            v = -int'($urandom_range(8388608, 14401));
        end else if (pick < 22) begin
            v = int'($urandom);
        end else if (pick < 30) begin
            case ($urandom_range(6))
                0:       v = 8388607;
                1:       v = -8388608;
                2:       v = -14400;
                3:       v = -14401;
                4:       v = -1;
                5:       v = 1;
                default: v = 0;
            endcase
        end else begin
            if ($urandom_range(39) == 0) begin
                load_level = int'($urandom_range(200000)) - 14400;
            end
            v = load_level + int'($urandom_range(400)) - 200;
        end
        return v[WEIGHT_W-1:0];
    endfunction

    // Offers one sample and returns once it has been accepted. The caller is
    // always just past a rising edge, so valid is either held or lowered for
    // a gap here, never both within one step.
    task automatic offer_sample(input logic signed [WEIGHT_W-1:0] sample,
                                input bit typed, input reading_t typed_result);
        reading_t predicted;
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= sample;
        do @(posedge aclk); while (!s_tready);
        predicted = trimmed_mean_step(sample);
        pending_readings.push_back(typed ? typed_result : predicted);
    endtask

    // Result side: checks every accepted result item against the oldest
    // pending one, then decides whether to stall in the next cycle. The long
    // hold-off is counted here so that the sender keeps offering samples and
    // the pipeline has to fill and stall its input.
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;

    always @(posedge aclk) begin
        reading_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_readings.size() == 0) begin
                $display("%0t: result item with none pending: expected nothing, got %0d held %0b",
                         $time, $signed(m_tdata), m_tuser);
                error_count++;
            end else begin
                want = pending_readings.pop_front();
                if (m_tdata !== want.weight) begin
                    $display("%0t: filtered weight mismatch: expected %0d, got %0d",
                             $time, want.weight, $signed(m_tdata));
                    error_count++;
                end
                if (m_tuser !== want.held) begin
                    $display("%0t: held flag mismatch: expected %0b, got %0b",
                             $time, want.held, m_tuser);
                    error_count++;
                end
            end
        end
        if (hold_left != 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else if (long_hold_armed && !hold_done) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: run timed out with %0d result items pending",
                     $time, pending_readings.size());
            $display("sliding_trimmed_mean_filter_tb: done, errors");
            $finish;
        end
    end

    initial begin
        reading_t typed_result;
        foreach (window_samples[i]) window_samples[i] = '0;
        oldest_slot = 0;
        held_weight = '0;

        // Synchronous reset, once only.
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // First phase: the sender idles now and then, the receiver mostly.
        send_idle = 31;
        recv_idle = 76;
        foreach (directed_rows[i]) begin
            typed_result.weight = directed_rows[i].weight;
            typed_result.held   = directed_rows[i].held;
            offer_sample(directed_rows[i].sample, directed_rows[i].typed, typed_result);
        end
        repeat (ITEMS_PER_PHASE) offer_sample(random_sample(), 1'b0, '0);

        // Second phase: the other way round.
        send_idle = 76;
        recv_idle = 31;
        repeat (ITEMS_PER_PHASE) offer_sample(random_sample(), 1'b0, '0);

        // Third phase: no idling on either side, opened by the long hold-off.
        send_idle = 0;
        recv_idle = 0;
        long_hold_armed = 1'b1;
        repeat (ITEMS_PER_PHASE) offer_sample(random_sample(), 1'b0, '0);
        s_tvalid <= 1'b0;

        // Let the pipeline drain, then watch a little longer for stray items.
        while (pending_readings.size() != 0) @(posedge aclk);
        repeat (LATENCY * 4) @(posedge aclk);

        if (error_count == 0) begin
            $display("sliding_trimmed_mean_filter_tb: done, clean");
        end else begin
            $display("sliding_trimmed_mean_filter_tb: done, errors");
        end
        $finish;
    end

endmodule

### filelist.f
design/stm_pkg.sv
design/stm_recip_div.sv
design/sliding_trimmed_mean_filter.sv
test/sliding_trimmed_mean_filter_tb.sv
